// ----- rtl/obbrc_pkg.sv -----
// shared types, constants and arithmetic helpers for the box/rectangle collision test
package obbrc_pkg;

    localparam int W      = 16;
    localparam int F      = W - 2;
    localparam int FW     = 48;
    localparam int RW     = 32;
    localparam int DW     = 24;
    localparam int PW     = 2 * W + 4;
    localparam int BW     = 2 * W + 9;
    localparam int CW     = 2 * W + 3;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int ODEPTH = 8;
    localparam int OAW    = $clog2(ODEPTH);
    localparam int NST    = 7;

    typedef logic signed [W:0]    t_diff;
    typedef logic signed [W-1:0]  t_lane;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic [BW-1:0]        t_proj;
    // rounded normal component, up to 2^(W+1) in magnitude
    typedef logic signed [W+2:0]  t_norm;
    // rounded projection magnitude, up to 3 * 2^(W+2)
    typedef logic [W+3:0]         t_mag;

    // one query split into lanes and with the center difference formed
    typedef struct packed {
        t_diff [2:0]      d;
        t_lane [2:0][2:0] ax;
        logic [2:0][W-1:0] hs;
        t_lane [1:0][2:0] ra;
        logic [1:0][W-1:0] rh;
    } t_query;

    // one finished result
    typedef struct packed {
        logic                 hit;
        logic                 depth_valid;
        logic signed [DW-1:0] depth;
    } t_result;

    // signed lane i of a packed field
    function automatic t_lane lane_s(input logic [FW-1:0] f, input int i);
        return t_lane'(f[i*W +: W]);
    endfunction

    // divide by 2^F, nearest, halves away from zero
    function automatic logic signed [BW+1:0] rnd_frac(input logic signed [BW+1:0] x);
        logic [BW+1:0] m;
        logic [BW+1:0] r;
        m = x[BW+1] ? -x : x;
        r = (m + (BW+2)'(1 << (F - 1))) >> F;
        return x[BW+1] ? -$signed(r) : $signed(r);
    endfunction

endpackage

// ----- rtl/obbrc_front.sv -----
// front part: accepts queries, splits lanes and forms the center difference
module obbrc_front
    import obbrc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [FW-1:0]   i_box_center,
    input  logic [FW-1:0]   i_box_axis_a,
    input  logic [FW-1:0]   i_box_axis_b,
    input  logic [FW-1:0]   i_box_axis_c,
    input  logic [FW-1:0]   i_box_half_sizes,
    input  logic [FW-1:0]   i_rect_center,
    input  logic [FW-1:0]   i_rect_axis_u,
    input  logic [FW-1:0]   i_rect_axis_v,
    input  logic [RW-1:0]   i_rect_half_sizes,
    output logic            o_q_valid,
    output t_query          o_q,
    input  logic            i_q_pop
);

    t_query             n_q;
    t_query             r_mem [QDEPTH];
    logic [QAW-1:0]     r_wp;
    logic [QAW-1:0]     r_rp;
    logic [QAW:0]       r_cnt;
    logic               w_push;

    // split fields into lanes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_q.d[i]     = t_diff'(lane_s(i_box_center, i)) - t_diff'(lane_s(i_rect_center, i));
            n_q.ax[0][i] = lane_s(i_box_axis_a, i);
            n_q.ax[1][i] = lane_s(i_box_axis_b, i);
            n_q.ax[2][i] = lane_s(i_box_axis_c, i);
            n_q.hs[i]    = i_box_half_sizes[i*W +: W];
            n_q.ra[0][i] = lane_s(i_rect_axis_u, i);
            n_q.ra[1][i] = lane_s(i_rect_axis_v, i);
        end
        n_q.rh[0] = i_rect_half_sizes[0 +: W];
        n_q.rh[1] = i_rect_half_sizes[W +: W];
    end

    assign o_stall   = (r_cnt == (QAW+1)'(QDEPTH));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign o_q       = r_mem[r_rp];

    // request queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= n_q;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(w_push) - (QAW+1)'(i_q_pop);
        end
    end

endmodule

// ----- rtl/obbrc_back.sv -----
// back part: pipelined separating-axis test with output skid queue
module obbrc_back
    import obbrc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  t_query          i_q,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output t_result         o_res
);

    // stage 1: dot products of axes and of the normal cross terms
    t_prod [1:0][2:0] n_s1_axd;
    t_prod [1:0]      n_s1_dd;
    t_prod [2:0]      n_s1_cr;
    t_prod [1:0][2:0] r_s1_axd;
    t_prod [1:0]      r_s1_dd;
    t_prod [2:0]      r_s1_cr;
    t_query           r_s1_q;

    // stage 2: rounded magnitudes and the normal
    t_mag [1:0][2:0]  r_s2_p;
    t_prod [1:0]      r_s2_dd;
    t_norm [2:0]      r_s2_n;
    t_query           r_s2_q;

    // stage 3: in-plane projections, normal dots
    t_proj [1:0]      r_s3_rb;
    logic [1:0][CW:0] r_s3_dist;
    t_prod [2:0]      r_s3_nad;
    t_prod            r_s3_ndd;
    t_query           r_s3_q;

    // stage 4: in-plane verdict, normal magnitudes
    logic             r_s4_sep;
    t_mag [2:0]       r_s4_p;
    logic [PW-1:0]    r_s4_dist;
    t_query           r_s4_q;

    // stage 5: normal box projection
    logic             r_s5_sep;
    t_proj            r_s5_rb;
    logic [PW-1:0]    r_s5_dist;

    // stage 6: result
    t_result          r_s6;

    logic [NST-2:0]   r_vld;
    logic             w_adv;

    // output skid queue, deep enough for the whole pipeline plus one
    t_result          r_ob [ODEPTH];
    logic [OAW-1:0]   r_owp;
    logic [OAW-1:0]   r_orp;
    logic [OAW:0]     r_ocnt;
    logic [OAW:0]     r_inflight;
    logic             w_take;
    logic             w_opush;

    function automatic t_mag rmag(input t_prod x);
        logic signed [BW+1:0] r;
        r = rnd_frac((BW+2)'(x));
        return r[BW+1] ? t_mag'(-r) : t_mag'(r);
    endfunction

    function automatic logic [PW-1:0] pmag(input t_prod x);
        return x[PW-1] ? PW'(-x) : PW'(x);
    endfunction

    // pipeline moves freely; credit keeps queue room for everything in flight
    assign w_adv   = 1'b1;
    assign o_q_pop = i_q_valid && ((r_inflight + r_ocnt) < (OAW+1)'(ODEPTH));
    assign w_opush = r_vld[NST-2];
    assign w_take  = o_valid && !i_stall;

    // stage 1 combinational
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_s1_axd[i][k] = PW'(i_q.ax[k][0] * i_q.ra[i][0])
                               + PW'(i_q.ax[k][1] * i_q.ra[i][1])
                               + PW'(i_q.ax[k][2] * i_q.ra[i][2]);
            end
            n_s1_dd[i] = PW'(i_q.d[0] * i_q.ra[i][0]) + PW'(i_q.d[1] * i_q.ra[i][1])
                       + PW'(i_q.d[2] * i_q.ra[i][2]);
        end
        n_s1_cr[0] = PW'(i_q.ra[0][1] * i_q.ra[1][2]) - PW'(i_q.ra[0][2] * i_q.ra[1][1]);
        n_s1_cr[1] = PW'(i_q.ra[0][2] * i_q.ra[1][0]) - PW'(i_q.ra[0][0] * i_q.ra[1][2]);
        n_s1_cr[2] = PW'(i_q.ra[0][0] * i_q.ra[1][1]) - PW'(i_q.ra[0][1] * i_q.ra[1][0]);
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        logic signed [BW+1:0] t;
        logic signed [BW+1:0] df;
        logic signed [BW+1:0] dp;
        r_s1_axd <= n_s1_axd;
        r_s1_dd  <= n_s1_dd;
        r_s1_cr  <= n_s1_cr;
        r_s1_q   <= i_q;
        for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < 3; k++) r_s2_p[i][k] <= rmag(r_s1_axd[i][k]);
        end
        for (int j = 0; j < 3; j++) begin
            t = rnd_frac((BW+2)'(r_s1_cr[j]));
            r_s2_n[j] <= t_norm'(t);
        end
        r_s2_dd <= r_s1_dd;
        r_s2_q  <= r_s1_q;
        for (int i = 0; i < 2; i++) begin
            r_s3_rb[i] <= BW'(r_s2_q.hs[0] * r_s2_p[i][0]) + BW'(r_s2_q.hs[1] * r_s2_p[i][1])
                        + BW'(r_s2_q.hs[2] * r_s2_p[i][2]);
            r_s3_dist[i] <= (CW+1)'(pmag(r_s2_dd[i]));
        end
        for (int k = 0; k < 3; k++) begin
            r_s3_nad[k] <= PW'(r_s2_q.ax[k][0] * r_s2_n[0]) + PW'(r_s2_q.ax[k][1] * r_s2_n[1])
                         + PW'(r_s2_q.ax[k][2] * r_s2_n[2]);
        end
        r_s3_ndd <= PW'(r_s2_q.d[0] * r_s2_n[0]) + PW'(r_s2_q.d[1] * r_s2_n[1])
                  + PW'(r_s2_q.d[2] * r_s2_n[2]);
        r_s3_q   <= r_s2_q;
        r_s4_sep <= ((BW+1)'(r_s3_dist[0]) > (BW+1)'({r_s3_q.rh[0], F'(0)}) + (BW+1)'(r_s3_rb[0]))
                 || ((BW+1)'(r_s3_dist[1]) > (BW+1)'({r_s3_q.rh[1], F'(0)}) + (BW+1)'(r_s3_rb[1]));
        for (int k = 0; k < 3; k++) r_s4_p[k] <= rmag(r_s3_nad[k]);
        r_s4_dist <= pmag(r_s3_ndd);
        r_s4_q    <= r_s3_q;
        r_s5_sep  <= r_s4_sep;
        r_s5_rb   <= BW'(r_s4_q.hs[0] * r_s4_p[0]) + BW'(r_s4_q.hs[1] * r_s4_p[1])
                   + BW'(r_s4_q.hs[2] * r_s4_p[2]);
        r_s5_dist <= r_s4_dist;
        df = $signed((BW+2)'(r_s5_rb)) - $signed((BW+2)'(r_s5_dist));
        dp = rnd_frac(df);
        if (r_s5_sep) begin
            r_s6 <= '{hit: 1'b0, depth_valid: 1'b0, depth: '0};
        end else begin
            r_s6.hit         <= !((BW+2)'(r_s5_dist) > (BW+2)'(r_s5_rb));
            r_s6.depth_valid <= 1'b1;
            if (dp > (BW+2)'(8388607)) r_s6.depth <= 24'sh7FFFFF;
            else if (dp < -(BW+2)'(8388608)) r_s6.depth <= 24'sh800000;
            else r_s6.depth <= DW'(dp);
        end
        if (w_opush) r_ob[r_owp] <= r_s6;
    end

    // valid pipeline and output queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_owp      <= '0;
            r_orp      <= '0;
            r_ocnt     <= '0;
            r_inflight <= '0;
        end else if (w_adv) begin
            r_vld  <= {r_vld[NST-3:0], o_q_pop};
            if (w_opush) r_owp <= r_owp + 1'b1;
            if (w_take) r_orp <= r_orp + 1'b1;
            r_ocnt <= r_ocnt + (OAW+1)'(w_opush) - (OAW+1)'(w_take);
            r_inflight <= r_inflight + (OAW+1)'(o_q_pop) - (OAW+1)'(w_opush);
        end
    end

    assign o_valid = (r_ocnt != '0);
    assign o_res   = r_ob[r_orp];

endmodule

// ----- rtl/obb_rectangle_collision_test_top.sv -----
// Box/rectangle separating-axis collision test, top level.
// Input channel: i_valid / o_stall with one query of box and rectangle fields.
// Output channel: o_valid / i_stall with hit, depth_valid and depth.
// A query is taken when valid is high and stall is low at a rising edge.
// From acceptance a query passes the input queue, the six-stage arithmetic
// pipeline and the output queue before its result shows.
// Throughput: one query per cycle while the receiver does not stall; the
// back end holds eight credits against its eight-entry output queue, which
// covers the six pipeline stages plus the result being handed over.
// The input queue holds four queries so the sender sees stall only
// once it fills.
// Reset (synchronous, active low) empties both queues and the pipeline.
// When the receiver stalls, results wait in the output queue, the credit
// stops new issue, and the input queue then fills and raises o_stall.
module obb_rectangle_collision_test_top
    import obbrc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [FW-1:0]        i_box_center,
    input  logic [FW-1:0]        i_box_axis_a,
    input  logic [FW-1:0]        i_box_axis_b,
    input  logic [FW-1:0]        i_box_axis_c,
    input  logic [FW-1:0]        i_box_half_sizes,
    input  logic [FW-1:0]        i_rect_center,
    input  logic [FW-1:0]        i_rect_axis_u,
    input  logic [FW-1:0]        i_rect_axis_v,
    input  logic [RW-1:0]        i_rect_half_sizes,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_hit,
    output logic                 o_depth_valid,
    output logic signed [DW-1:0] o_depth
);

    logic    w_q_valid;
    logic    w_q_pop;
    t_query  w_q;
    t_result w_res;

    // front end with request queue
    obbrc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_box_center, .i_box_axis_a, .i_box_axis_b, .i_box_axis_c,
        .i_box_half_sizes, .i_rect_center, .i_rect_axis_u, .i_rect_axis_v,
        .i_rect_half_sizes,
        .o_q_valid(w_q_valid), .o_q(w_q), .i_q_pop(w_q_pop)
    );

    // back end arithmetic
    obbrc_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .i_q(w_q), .o_q_pop(w_q_pop),
        .o_valid, .i_stall, .o_res(w_res)
    );

    assign o_hit         = w_res.hit;
    assign o_depth_valid = w_res.depth_valid;
    assign o_depth       = w_res.depth;

endmodule

// ----- rtl/obbrc_checker.sv -----
// port-level checks for the collision test, bound to the top level
module obbrc_checker
    import obbrc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic                 o_hit,
    input logic                 o_depth_valid,
    input logic signed [DW-1:0] o_depth
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_depth) && $stable(o_hit))
        else $error("stalled result changed");

    // a hit always carries a valid depth
    a_hit_dv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_depth_valid)
        else $error("hit without depth");

    // in-plane separation forces a zero depth
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_depth_valid |-> o_depth == '0 && !o_hit)
        else $error("depth not cleared");

    // a hit has a non-negative depth
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_depth[DW-1])
        else $error("hit with negative depth");

    // nothing shows right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");

endmodule

bind obb_rectangle_collision_test_top obbrc_checker u_chk (.*);
